/* rtl/differential_drive_odometry_top_defines.svh */
// Assertion macros used by the odometry sequencer.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property while out of reset.
`define DDO_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// Check a property on every edge, reset included.
`define DDO_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");
`else
`define DDO_ASSERT(lbl, clk, rst_n, prop)
`define DDO_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/ddo_pkg.sv */
// Types, constants and elaboration helpers for the odometry block.
package ddo_pkg;

    localparam int SC_FRAC   = 48;
    localparam int SW        = 52;
    localparam int MUL_AW    = 48;
    localparam int MUL_BW    = 64;
    localparam int MUL_CHUNK = 16;
    localparam int MUL_STEPS = MUL_AW / MUL_CHUNK;
    localparam int MUL_PW    = MUL_AW + MUL_BW;
    localparam int DIV_NW    = 94;
    localparam int DIV_DW    = 64;

    localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
    localparam logic [63:0] INV_GAIN_Q62 = 64'd2800459870029452954;
    localparam logic [SW-1:0] CORDIC_X0 =
        SW'((INV_GAIN_Q62 + (64'd1 << (61 - SC_FRAC))) >> (62 - SC_FRAC));
    localparam logic [31:0] TWO_PI_Q29 = 32'((PI_Q60 + (64'd1 << 29)) >> 30);
    localparam logic [MUL_PW-1:0] LIM48 = MUL_PW'(64'h0001_0000_0000_0000);
    localparam logic [63:0] RAD_MAX = 64'h0000_7FFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] left_distance;
        logic signed [31:0] right_distance;
    } t_in_beat;

    typedef struct packed {
        logic signed [47:0] new_x;
        logic signed [47:0] new_y;
        logic [31:0]        new_heading;
        logic               straight_move;
    } t_out_beat;

    typedef enum logic [3:0] {
        OP_ZMUL0 = 4'd0,
        OP_ZMUL1 = 4'd1,
        OP_COR0  = 4'd2,
        OP_COR1  = 4'd3,
        OP_TURN  = 4'd4,
        OP_RMUL  = 4'd5,
        OP_RDIV  = 4'd6,
        OP_MULX  = 4'd7,
        OP_MULY  = 4'd8
    } t_op;

    typedef struct packed {
        logic load;
        logic start;
        t_op  op;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic busy;
        logic straight;
    } t_status;

    // atan(2^-i) in Q.62 from the alternating series; elaboration use only.
    function automatic logic [63:0] atan_q62(input int unsigned i);
        logic [63:0] acc;
        int          e;
        acc = '0;
        if (i == 0) return PI_Q60;
        for (int k = 0; k < 64; k++) begin
            e = 62 - int'(i) * (2 * k + 1);
            if (e >= 0) begin
                if ((k & 1) != 0) acc = acc - ((64'd1 << e) / 64'(2 * k + 1));
                else acc = acc + ((64'd1 << e) / 64'(2 * k + 1));
            end
        end
        return acc;
    endfunction

endpackage

/* rtl/ddo_ctrl.sv */
// Sequencer that steps the odometry datapath through one update.
`include "differential_drive_odometry_top_defines.svh"
module ddo_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ddo_pkg::t_cmd    o_cmd,
    input  ddo_pkg::t_status i_status
);
    import ddo_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_Z0   = 11'b00000000010,
        ST_C0   = 11'b00000000100,
        ST_TURN = 11'b00000001000,
        ST_RMUL = 11'b00000010000,
        ST_RDIV = 11'b00000100000,
        ST_Z1   = 11'b00001000000,
        ST_C1   = 11'b00010000000,
        ST_MX   = 11'b00100000000,
        ST_MY   = 11'b01000000000,
        ST_OUT  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   has_op;
    t_op    next_op;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_Z0;
                end
            end
            ST_Z0:   if (i_status.done) n_state = ST_C0;
            ST_C0:   if (i_status.done) n_state = i_status.straight ? ST_MX : ST_TURN;
            ST_TURN: if (i_status.done) n_state = ST_RMUL;
            ST_RMUL: if (i_status.done) n_state = ST_RDIV;
            ST_RDIV: if (i_status.done) n_state = ST_Z1;
            ST_Z1:   if (i_status.done) n_state = ST_C1;
            ST_C1:   if (i_status.done) n_state = ST_MX;
            ST_MX:   if (i_status.done) n_state = ST_MY;
            ST_MY:   if (i_status.done) n_state = ST_OUT;
            ST_OUT: begin
                // hold until the output slot is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        has_op  = 1'b1;
        next_op = OP_ZMUL0;
        case (n_state)
            ST_Z0:   next_op = OP_ZMUL0;
            ST_C0:   next_op = OP_COR0;
            ST_TURN: next_op = OP_TURN;
            ST_RMUL: next_op = OP_RMUL;
            ST_RDIV: next_op = OP_RDIV;
            ST_Z1:   next_op = OP_ZMUL1;
            ST_C1:   next_op = OP_COR1;
            ST_MX:   next_op = OP_MULX;
            ST_MY:   next_op = OP_MULY;
            default: has_op  = 1'b0;
        endcase
        o_cmd.op    = next_op;
        o_cmd.start = has_op && (n_state != r_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    `DDO_ASSERT(a_start_unit_free, i_clk, i_rst_n, o_cmd.start |-> !i_status.busy)
    `DDO_ASSERT(a_done_in_op, i_clk, i_rst_n,
                i_status.done |-> (r_state != ST_IDLE && r_state != ST_OUT))
    `DDO_ASSERT(a_accept_starts, i_clk, i_rst_n,
                (i_in_valid && o_in_ready) |=> (r_state == ST_Z0 && i_status.busy))
    `DDO_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == ST_IDLE && !r_out_valid))

endmodule

/* rtl/ddo_datapath.sv */
// Pose registers, config registers and the shared multiply, divide and CORDIC units.
module ddo_datapath #(
    parameter int CORDIC_ITERATIONS = 24,
    parameter int ANGLE_BITS        = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    input  ddo_pkg::t_cmd     i_cmd,
    output ddo_pkg::t_status  o_status,
    input  ddo_pkg::t_in_beat i_in_data,
    output ddo_pkg::t_out_beat o_out_data
);
    import ddo_pkg::*;

    localparam int ZW  = ANGLE_BITS + 3;
    localparam int ZSH = 91 - ANGLE_BITS;
    localparam int IW  = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;

    logic [30:0]             r_track;
    logic [15:0]             r_thr;
    logic signed [47:0]      r_pose_x, r_pose_y;
    logic [31:0]             r_heading, r_newh;
    logic signed [33:0]      r_sum, r_diff;
    logic [32:0]             r_ad;
    logic                    r_straight;
    logic [62:0]             r_tw2pi;
    logic signed [SW-1:0]    r_c0, r_s0, r_c1, r_s1, r_cx, r_cy;
    logic signed [ZW-1:0]    r_cz;
    logic [1:0]              r_quad;
    logic [46:0]             r_rad_mag;
    logic                    r_rad_neg;
    logic [MUL_AW-1:0]       r_ma;
    logic [MUL_BW-1:0]       r_mb;
    logic [MUL_PW-1:0]       r_macc;
    logic                    r_mneg;
    logic [DIV_NW-1:0]       r_dnum;
    logic [DIV_DW-1:0]       r_drem, r_dq, r_dden;
    logic                    r_busy, r_done;
    t_op                     r_op;
    logic [6:0]              r_cnt;
    t_out_beat               r_out;

    logic signed [ZW-1:0]    atan_tab [CORDIC_ITERATIONS];

    for (genvar gi = 0; gi < CORDIC_ITERATIONS; gi++) begin : g_atan
        localparam logic [63:0] A_RND =
            (atan_q62(gi) + (64'd1 << (61 - ANGLE_BITS))) >> (62 - ANGLE_BITS);
        assign atan_tab[gi] = ZW'(A_RND);
    end

    // load-time values
    logic signed [33:0] in_sum, in_diff;
    logic [32:0]        in_ad;
    assign in_sum  = 34'(i_in_data.left_distance) + 34'(i_in_data.right_distance);
    assign in_diff = 34'(i_in_data.right_distance) - 34'(i_in_data.left_distance);
    assign in_ad   = in_diff[33] ? 33'(-in_diff) : 33'(in_diff);

    // operand selection at unit start
    logic [31:0]          st_ang, st_hs;
    logic signed [30:0]   st_zr;
    logic [29:0]          zr_mag;
    logic [33:0]          sum_mag;
    logic [SW-1:0]        c0_mag, s0_mag;
    logic signed [SW:0]   ds, dc;
    logic [SW:0]          ds_mag, dc_mag;
    logic [MUL_AW-1:0]    sel_a;
    logic [MUL_BW-1:0]    sel_b;
    logic                 sel_neg;

    always_comb begin
        st_ang  = (i_cmd.op == OP_ZMUL1) ? r_newh : r_heading;
        st_hs   = st_ang + 32'h2000_0000;
        st_zr   = $signed({1'b0, st_hs[29:0]}) - 31'sh2000_0000;
        zr_mag  = st_zr[30] ? 30'(-st_zr) : 30'(st_zr);
        sum_mag = r_sum[33] ? 34'(-r_sum) : 34'(r_sum);
        c0_mag  = r_c0[SW-1] ? SW'(-r_c0) : SW'(r_c0);
        s0_mag  = r_s0[SW-1] ? SW'(-r_s0) : SW'(r_s0);
        ds      = {r_s1[SW-1], r_s1} - {r_s0[SW-1], r_s0};
        dc      = {r_c0[SW-1], r_c0} - {r_c1[SW-1], r_c1};
        ds_mag  = ds[SW] ? (SW+1)'(-ds) : (SW+1)'(ds);
        dc_mag  = dc[SW] ? (SW+1)'(-dc) : (SW+1)'(dc);
        sel_a   = MUL_AW'(zr_mag);
        sel_b   = PI_Q60;
        sel_neg = st_zr[30];
        case (i_cmd.op)
            OP_RMUL: begin
                sel_a   = MUL_AW'(sum_mag);
                sel_b   = MUL_BW'(r_track);
                sel_neg = 1'b0;
            end
            OP_MULX: begin
                if (r_straight) begin
                    sel_a   = MUL_AW'(sum_mag);
                    sel_b   = MUL_BW'(c0_mag);
                    sel_neg = r_sum[33] ^ r_c0[SW-1];
                end else begin
                    sel_a   = MUL_AW'(r_rad_mag);
                    sel_b   = MUL_BW'(ds_mag);
                    sel_neg = r_rad_neg ^ ds[SW];
                end
            end
            OP_MULY: begin
                if (r_straight) begin
                    sel_a   = MUL_AW'(sum_mag);
                    sel_b   = MUL_BW'(s0_mag);
                    sel_neg = r_sum[33] ^ r_s0[SW-1];
                end else begin
                    sel_a   = MUL_AW'(r_rad_mag);
                    sel_b   = MUL_BW'(dc_mag);
                    sel_neg = r_rad_neg ^ dc[SW];
                end
            end
            default: ;
        endcase
    end

    // multiplier: one 64x16 partial product per step, then round and apply
    logic                    is_mul, is_div, is_cor, fin;
    logic [MUL_BW+MUL_CHUNK-1:0] pp;
    logic [MUL_PW-1:0]       pp_sh, rnd, mv;
    logic [6:0]              mul_sh;
    logic [ZW-1:0]           zmag;
    logic [48:0]             mclamp;
    logic signed [49:0]      term;
    logic signed [47:0]      pose_sel;
    logic signed [50:0]      psum;
    logic signed [47:0]      psat;

    always_comb begin
        is_mul = (r_op == OP_ZMUL0) || (r_op == OP_ZMUL1) || (r_op == OP_RMUL) ||
                 (r_op == OP_MULX) || (r_op == OP_MULY);
        is_div = (r_op == OP_TURN) || (r_op == OP_RDIV);
        is_cor = (r_op == OP_COR0) || (r_op == OP_COR1);
        fin    = r_busy && ((is_mul && r_cnt == 7'(MUL_STEPS)) ||
                            (is_div && r_cnt == 7'(DIV_NW)) ||
                            (is_cor && r_cnt == 7'(CORDIC_ITERATIONS)));
        pp     = r_mb * r_ma[MUL_CHUNK-1:0];
        pp_sh  = MUL_PW'(pp) << {r_cnt[1:0], 4'b0000};
        if (r_op == OP_ZMUL0 || r_op == OP_ZMUL1) mul_sh = 7'(ZSH);
        else mul_sh = r_straight ? 7'(SC_FRAC + 1) : 7'(SC_FRAC);
        rnd    = r_macc + (MUL_PW'(1) << (mul_sh - 7'd1));
        mv     = rnd >> mul_sh;
        zmag   = ZW'(mv);
        mclamp = (mv > LIM48) ? 49'(LIM48) : mv[48:0];
        term   = r_mneg ? -$signed({1'b0, mclamp}) : $signed({1'b0, mclamp});
        pose_sel = (r_op == OP_MULX) ? r_pose_x : r_pose_y;
        psum   = 51'(pose_sel) + 51'(term);
        if (psum > 51'sh0_7FFF_FFFF_FFFF) psat = 48'sh7FFF_FFFF_FFFF;
        else if (psum < -51'sh0_8000_0000_0000) psat = -48'sh8000_0000_0000;
        else psat = psum[47:0];
    end

    // restoring divider, one quotient bit per step
    logic [DIV_DW:0]   rem_sh;
    logic              ge;
    logic [DIV_DW-1:0] rem_nx;
    logic [31:0]       turn;
    logic [63:0]       rq;

    always_comb begin
        rem_sh = {r_drem, r_dnum[DIV_NW-1]};
        ge     = rem_sh >= {1'b0, r_dden};
        rem_nx = ge ? DIV_DW'(rem_sh - {1'b0, r_dden}) : rem_sh[DIV_DW-1:0];
        turn   = r_diff[33] ? -r_dq[31:0] : r_dq[31:0];
        rq     = (r_dq > RAD_MAX) ? RAD_MAX : r_dq;
    end

    // CORDIC step and quadrant fold
    logic signed [ZW-1:0] cang;
    logic signed [SW-1:0] cdx, cdy, fc, fs;

    always_comb begin
        cang = atan_tab[r_cnt[IW-1:0]];
        cdx  = r_cy >>> r_cnt;
        cdy  = r_cx >>> r_cnt;
        case (r_quad)
            2'd0:    begin fc = r_cx;  fs = r_cy;  end
            2'd1:    begin fc = -r_cy; fs = r_cx;  end
            2'd2:    begin fc = -r_cx; fs = -r_cy; end
            default: begin fc = r_cy;  fs = -r_cx; end
        endcase
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= 31'd65536;
            r_thr   <= 16'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_thr <= pwdata[15:0];
            else r_track <= pwdata[30:0];
        end
    end
    assign prdata = paddr[2] ? {16'b0, r_thr} : {1'b0, r_track};

    // control and pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_cnt     <= '0;
            r_op      <= OP_ZMUL0;
            r_pose_x  <= '0;
            r_pose_y  <= '0;
            r_heading <= '0;
        end else begin
            r_done <= fin;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_cnt  <= '0;
            end else if (fin) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
            end
            if (fin && r_op == OP_MULX) r_pose_x <= psat;
            if (fin && r_op == OP_MULY) r_pose_y <= psat;
            if (i_cmd.commit && !r_straight) r_heading <= r_newh;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sum      <= in_sum;
            r_diff     <= in_diff;
            r_ad       <= in_ad;
            r_straight <= (r_track == '0) || (in_ad <= 33'(r_thr));
            r_tw2pi    <= r_track * TWO_PI_Q29;
        end
        if (i_cmd.start) begin
            case (i_cmd.op)
                OP_TURN: begin
                    r_dnum <= {r_ad, 61'b0};
                    r_dden <= {1'b0, r_tw2pi};
                    r_drem <= '0;
                    r_dq   <= '0;
                end
                OP_RDIV: begin
                    r_dnum <= r_macc[DIV_NW-1:0];
                    r_dden <= DIV_DW'({r_ad, 1'b0});
                    r_drem <= '0;
                    r_dq   <= '0;
                end
                OP_COR0, OP_COR1: begin
                    r_cx <= CORDIC_X0;
                    r_cy <= '0;
                end
                default: begin
                    r_ma   <= sel_a;
                    r_mb   <= sel_b;
                    r_mneg <= sel_neg;
                    r_macc <= '0;
                    if (i_cmd.op == OP_ZMUL0 || i_cmd.op == OP_ZMUL1) r_quad <= st_hs[31:30];
                end
            endcase
        end else if (r_busy && !fin) begin
            if (is_mul) begin
                r_macc <= r_macc + pp_sh;
                r_ma   <= r_ma >> MUL_CHUNK;
            end
            if (is_div) begin
                r_drem <= rem_nx;
                r_dq   <= {r_dq[DIV_DW-2:0], ge};
                r_dnum <= r_dnum << 1;
            end
            if (is_cor) begin
                if (!r_cz[ZW-1]) begin
                    r_cx <= r_cx - cdx;
                    r_cy <= r_cy + cdy;
                    r_cz <= r_cz - cang;
                end else begin
                    r_cx <= r_cx + cdx;
                    r_cy <= r_cy - cdy;
                    r_cz <= r_cz + cang;
                end
            end
        end else if (fin) begin
            case (r_op)
                OP_ZMUL0, OP_ZMUL1: r_cz <= r_mneg ? -$signed(zmag) : $signed(zmag);
                OP_COR0: begin
                    r_c0 <= fc;
                    r_s0 <= fs;
                end
                OP_COR1: begin
                    r_c1 <= fc;
                    r_s1 <= fs;
                end
                OP_TURN: r_newh <= r_heading + turn;
                OP_RDIV: begin
                    r_rad_mag <= rq[46:0];
                    r_rad_neg <= r_sum[33] ^ r_diff[33];
                end
                default: ;
            endcase
        end
        if (i_cmd.commit) begin
            r_out.new_x         <= r_pose_x;
            r_out.new_y         <= r_pose_y;
            r_out.new_heading   <= r_straight ? r_heading : r_newh;
            r_out.straight_move <= r_straight;
        end
    end

    assign o_status.done     = r_done;
    assign o_status.busy     = r_busy;
    assign o_status.straight = r_straight;
    assign o_out_data        = r_out;

endmodule

/* rtl/differential_drive_odometry_top.sv */
// Top level of the differential-drive odometry block.
// Each input beat carries left and right wheel travel (signed Q16.16); each output
// beat carries the updated pose: x and y in saturating Q32.16 and the heading as a
// 32-bit binary angle that wraps on its own, plus a flag for a straight move. A
// move counts as straight when the wheel difference magnitude is at most
// straight_threshold (or track_width is zero); otherwise the pose follows an arc.
// One beat is worked at a time. An arc takes longer than a straight move; its time
// is set mostly by two passes through the 94-step restoring divider (turn angle,
// then radius) and two CORDIC runs of one micro-rotation per cycle, where a straight
// move makes one CORDIC run. The result sits in an output register, so the next
// beat is accepted while it waits. Registers: track_width at byte 0, and
// straight_threshold at byte 4; write them only while the block is idle.
// The pose clears to zero at reset.
module differential_drive_odometry_top #(
    parameter int CORDIC_ITERATIONS = 24,
    parameter int ANGLE_BITS        = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input beats
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ddo_pkg::t_in_beat  i_in_data,
    // result beats
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ddo_pkg::t_out_beat o_out_data,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ddo_pkg::*;

    t_cmd    cmd;
    t_status status;

    // zero-wait-state register port
    assign pready = 1'b1;

    // sequencer: accept, step each unit, commit the pose
    ddo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // arithmetic units, pose and registers
    ddo_datapath #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .ANGLE_BITS        (ANGLE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule
